/* sv/osem_pkg.sv */
// shared constants, types and status codes of the owned counting semaphore
`default_nettype none
package osem_pkg;

  localparam int unsigned QueueDepth   = 16;
  localparam int unsigned TaskIdBits   = 8;
  localparam int unsigned TaskIdPortW  = 8;
  localparam int unsigned TidW         = (TaskIdBits < TaskIdPortW) ? TaskIdBits : TaskIdPortW;
  localparam int unsigned FillW        = $clog2(QueueDepth + 1);
  localparam logic [7:0]  CountMax     = 8'hFF;
  localparam logic [7:0]  InitCountRst = 8'd1;

  typedef logic [TidW-1:0]  tid_t;
  typedef logic [FillW-1:0] fill_t;

  typedef enum logic [2:0] {
    StGranted  = 3'd0,
    StIgnored  = 3'd1,
    StQueued   = 3'd2,
    StHanded   = 3'd3,
    StRaised   = 3'd4,
    StNotOwner = 3'd5,
    StFull     = 3'd6
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
    tid_t push_tid;
  } q_ctrl_t;

  typedef struct packed {
    fill_t fill;
    tid_t  head_tid;
  } q_stat_t;

endpackage
`default_nettype wire

/* sv/osem_intf.sv */
// request, response and configuration channel interfaces
`default_nettype none
interface osem_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] task_id;
  modport source (output valid, output mode, output task_id, input ready);
  modport sink (input valid, input mode, input task_id, output ready);
endinterface

interface osem_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       wake_valid;
  logic [7:0] wake_task;
  logic [7:0] count_now;
  logic [4:0] waiting_now;
  modport source (output valid, output status, output wake_valid, output wake_task,
                  output count_now, output waiting_now, input ready);
  modport sink (input valid, input status, input wake_valid, input wake_task,
                input count_now, input waiting_now, output ready);
endinterface

interface osem_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] initial_count;
  modport source (output valid, output initial_count, input ready);
  modport sink (input valid, input initial_count, output ready);
endinterface
`default_nettype wire

/* sv/owned_counting_semaphore.sv */
// owned counting semaphore with a fifo wait queue built from a chain of cells
// a request's result is registered and shows in the cycle after its transfer
// throughput: one request per cycle; the next request is taken while the result waits,
//   as long as the response register is free or being drained in the same cycle
// reset: count = 1, no owner, queue empty; queue cells themselves are not cleared
// a configuration transfer reloads the free unit count, owner and queue stay
`default_nettype none
module owned_counting_semaphore (
  input  wire          clk_i,
  input  wire          rst_ni,
  osem_cfg_if.sink     cfg_i,
  osem_req_if.sink     req_i,
  osem_rsp_if.source   rsp_o
);
  import osem_pkg::*;

  // semaphore state
  logic [7:0] free_units_q, free_units_d;
  tid_t       owner_tid_q, owner_tid_d;
  logic       owner_valid_q, owner_valid_d;

  // response register
  logic       rsp_valid_q;
  status_e    status_q, status_d;
  logic       wake_valid_q, wake_valid_d;
  logic [7:0] wake_task_q, wake_task_d;
  logic [7:0] count_q;
  logic [4:0] waiting_q, waiting_d;

  q_ctrl_t q_ctrl;
  q_stat_t q_stat;

  logic  req_xfer;
  tid_t  tid;
  logic  is_owner;
  logic  q_empty;
  logic  q_full;
  fill_t fill_after;

  // a new request moves in whenever the response slot is free or drains now
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_xfer    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // only the low TidW task id bits take part; with the package values that is all eight
  assign tid      = req_i.task_id[TidW-1:0];
  assign is_owner = owner_valid_q && (owner_tid_q == tid);
  assign q_empty  = (q_stat.fill == '0);
  assign q_full   = (q_stat.fill == FillW'(QueueDepth));

  always_comb begin
    free_units_d    = free_units_q;
    owner_tid_d     = owner_tid_q;
    owner_valid_d   = owner_valid_q;
    status_d        = StNotOwner;
    wake_valid_d    = 1'b0;
    wake_task_d     = '0;
    q_ctrl.push     = 1'b0;
    q_ctrl.pop      = 1'b0;
    q_ctrl.push_tid = tid;

    if (!req_i.mode) begin
      // down request
      if (is_owner) begin
        status_d = StIgnored;
      end else if (free_units_q != '0) begin
        free_units_d  = free_units_q - 8'd1;
        owner_tid_d   = tid;
        owner_valid_d = 1'b1;
        status_d      = StGranted;
      end else if (!q_full) begin
        q_ctrl.push = req_xfer;
        status_d    = StQueued;
      end else begin
        status_d = StFull;
      end
    end else begin
      // up request
      if (!is_owner) begin
        status_d = StNotOwner;
      end else if (q_empty) begin
        // count saturates, ownership is released either way
        if (free_units_q != CountMax) begin
          free_units_d = free_units_q + 8'd1;
        end
        owner_valid_d = 1'b0;
        owner_tid_d   = '0;
        status_d      = StRaised;
      end else begin
        // oldest waiter sits in the head cell and takes over ownership
        q_ctrl.pop    = req_xfer;
        wake_valid_d  = 1'b1;
        wake_task_d   = 8'(q_stat.head_tid);
        owner_tid_d   = q_stat.head_tid;
        owner_valid_d = 1'b1;
        status_d      = StHanded;
      end
    end
  end

  // queue occupancy as the response reports it
  always_comb begin
    fill_after = q_stat.fill;
    if (q_ctrl.push) begin
      fill_after = q_stat.fill + FillW'(1);
    end else if (q_ctrl.pop) begin
      fill_after = q_stat.fill - FillW'(1);
    end
    waiting_d = 5'(fill_after);
  end

  osem_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .stat_o (q_stat)
  );

  // semaphore state; the user must send configuration only while idle, the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_units_q  <= InitCountRst;
      owner_tid_q   <= '0;
      owner_valid_q <= 1'b0;
    end else if (cfg_i.valid) begin
      free_units_q <= cfg_i.initial_count;
    end else if (req_xfer) begin
      free_units_q  <= free_units_d;
      owner_tid_q   <= owner_tid_d;
      owner_valid_q <= owner_valid_d;
    end
  end

  // response valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_xfer) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // response payload, loaded with each request transfer
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      status_q     <= status_d;
      wake_valid_q <= wake_valid_d;
      wake_task_q  <= wake_task_d;
      count_q      <= free_units_d;
      waiting_q    <= waiting_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.wake_valid  = wake_valid_q;
  assign rsp_o.wake_task   = wake_task_q;
  assign rsp_o.count_now   = count_q;
  assign rsp_o.waiting_now = waiting_q;
endmodule
`default_nettype wire

/* sv/osem_cell.sv */
// one wait queue slot: loads a new task id or takes its neighbor's id on dequeue
`default_nettype none
module osem_cell (
  input  wire                 clk_i,
  input  wire                 load_i,
  input  wire                 shift_i,
  input  osem_pkg::tid_t      new_tid_i,
  input  osem_pkg::tid_t      nbr_tid_i,
  output osem_pkg::tid_t      tid_o
);
  import osem_pkg::*;

  tid_t tid_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tid_q <= new_tid_i;
    end else if (shift_i) begin
      tid_q <= nbr_tid_i;
    end
  end

  assign tid_o = tid_q;
endmodule
`default_nettype wire

/* sv/osem_queue.sv */
// wait queue as a chain of cells, head in cell zero, fill count kept here
`default_nettype none
module osem_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  osem_pkg::q_ctrl_t   ctrl_i,
  output osem_pkg::q_stat_t   stat_o
);
  import osem_pkg::*;

  fill_t fill_q, fill_d;
  tid_t  cell_tid [QueueDepth];

  for (genvar k = 0; k < QueueDepth; k++) begin : g_cell
    tid_t nbr_tid;
    logic load;
    // last cell has no upper neighbor, its content is dead after a dequeue
    if (k == QueueDepth - 1) begin : g_last
      assign nbr_tid = cell_tid[k];
    end else begin : g_mid
      assign nbr_tid = cell_tid[k+1];
    end
    assign load = ctrl_i.push && (fill_q == FillW'(k));

    osem_cell u_cell (
      .clk_i     (clk_i),
      .load_i    (load),
      .shift_i   (ctrl_i.pop),
      .new_tid_i (ctrl_i.push_tid),
      .nbr_tid_i (nbr_tid),
      .tid_o     (cell_tid[k])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.push) begin
      fill_d = fill_q + FillW'(1);
    end else if (ctrl_i.pop) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign stat_o.fill     = fill_q;
  assign stat_o.head_tid = cell_tid[0];
endmodule
`default_nettype wire
